/* rtl/kmp_pkg.sv */
// Shared types, codes and the byte folding function of the KMP substring search.
package kmp_pkg;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_POST
  } kmp_state_t;

  // Result status codes
  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_MATCH     = 2'd1;
  localparam logic [1:0] ST_PAT_LONG  = 2'd2;
  localparam logic [1:0] ST_TEXT_LONG = 2'd3;

  // Configuration space
  localparam int unsigned     CFG_ADDR_W = 3;
  localparam logic [2:0]      REG_CASE   = 3'h0;

  // Controller to datapath
  typedef struct packed {
    logic take;   // latch the presented word and apply its first decision
    logic step;   // one compare of the failure-link walk
    logic emit;   // load the pending result into the output register
  } kmp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_walk;    // presented word starts a walk
    logic need_result;  // presented word answers at once
    logic walk_done;    // walk ends on this compare
    logic walk_result;  // finished walk produces a result
  } kmp_stat_t;

  // Lower ASCII A-Z when case-insensitive compare is on
  function automatic logic [7:0] kmp_fold(input logic [7:0] b, input logic ci);
    logic [7:0] r;
    r = b;
    if (ci && (b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

/* rtl/kmp_ctrl.sv */
// Controller state machine of the KMP substring search.
module kmp_ctrl import kmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  kmp_stat_t stat,
  output kmp_cmd_t  cmd
);

  kmp_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.need_walk) begin
            state_nxt = S_WALK;
          end else if (stat.need_result) begin
            state_nxt = S_POST;
          end
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_nxt = stat.walk_result ? S_POST : S_IDLE;
        end
      end
      S_POST: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_WALK: begin
        cmd.step = 1'b1;
      end
      S_POST: begin
        cmd.emit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Hold the output word until taken
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/kmp_datapath.sv */
// Datapath of the KMP substring search: pattern and failure memories, walk and text state.
module kmp_datapath import kmp_pkg::*; #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     case_insensitive,
  input  logic                     in_mode,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_last,
  input  kmp_cmd_t                 cmd,
  output kmp_stat_t                stat,
  output logic [1:0]               out_status,
  output logic [POSITION_BITS-1:0] out_position
);

  localparam int FW = $clog2(MAX_PATTERN + 1);
  localparam int JW = FW + 1;
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PB = POSITION_BITS;
  localparam int TW = PB + 1;
  localparam logic [FW-1:0] PLEN_FULL = FW'(MAX_PATTERN);
  localparam logic [TW-1:0] TP_SAT    = {1'b1, {(PB-1){1'b0}}, 1'b1};

  logic [7:0]    pat_mem  [MAX_PATTERN];
  logic [FW-1:0] fail_mem [MAX_PATTERN+1];
  logic [7:0]    pat_rd_r;
  logic [FW-1:0] fail_rd_r;

  logic [FW-1:0] plen_r, plen_nxt;
  logic [JW-1:0] pidx_r, pidx_nxt;
  logic          ovf_r, ovf_nxt;
  logic [FW-1:0] ml_r, ml_nxt;
  logic [TW-1:0] tp_r, tp_nxt;
  logic          done_r, done_nxt;
  logic          txt_r, txt_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic          mode_r, mode_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [PB-1:0] res_pos_r, res_pos_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [PB-1:0] out_pos_r, out_pos_nxt;

  logic          pat_full;
  logic          txt_sat;
  logic          cont;
  logic          hit;
  logic [JW-1:0] j_fail;
  logic [JW-1:0] j_inc;
  logic [TW-1:0] start;
  logic          pat_we;
  logic          fail_we;
  logic [AW-1:0] pat_waddr;
  logic [FW-1:0] fail_waddr;

  assign pat_full = !txt_r && (plen_r == PLEN_FULL);
  assign txt_sat  = tp_r[PB];

  // One compare of the walk; index minus one is the sign bit
  assign cont   = !j_r[JW-1] && (j_r[FW-1:0] < plen_r) &&
                  (kmp_fold(byte_r, case_insensitive) != kmp_fold(pat_rd_r, case_insensitive));
  assign j_fail = (j_r == '0) ? '1 : {1'b0, fail_rd_r};
  assign j_inc  = j_r + JW'(1);
  assign hit    = (j_inc[FW-1:0] >= plen_r);
  assign start  = tp_r - TW'(plen_r);

  always_comb begin
    stat = '0;
    if (!in_mode) begin
      stat.need_walk = !pat_full;
    end else if (!done_r) begin
      if (ovf_r || txt_sat) begin
        stat.need_result = in_last;
      end else if (plen_r == '0) begin
        stat.need_result = 1'b1;
      end else begin
        stat.need_walk = 1'b1;
      end
    end
    stat.walk_done   = !cont;
    stat.walk_result = mode_r && (hit || last_r);
  end

  always_comb begin
    plen_nxt       = plen_r;
    pidx_nxt       = pidx_r;
    ovf_nxt        = ovf_r;
    ml_nxt         = ml_r;
    tp_nxt         = tp_r;
    done_nxt       = done_r;
    txt_nxt        = txt_r;
    j_nxt          = j_r;
    mode_nxt       = mode_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;

    if (cmd.take) begin
      mode_nxt = in_mode;
      byte_nxt = in_data_byte;
      last_nxt = in_last;
      if (!in_mode) begin
        // a pattern word after text starts a new pattern
        if (txt_r) begin
          plen_nxt = '0;
          pidx_nxt = '1;
          ovf_nxt  = 1'b0;
          ml_nxt   = '0;
          tp_nxt   = '0;
          done_nxt = 1'b0;
        end
        txt_nxt = in_last;
        if (pat_full) begin
          ovf_nxt = 1'b1;
        end else begin
          j_nxt = txt_r ? '1 : pidx_r;
        end
      end else begin
        txt_nxt = 1'b1;
        if (done_r) begin
          if (in_last) begin
            ml_nxt   = '0;
            tp_nxt   = '0;
            done_nxt = 1'b0;
          end
        end else if (ovf_r) begin
          res_status_nxt = ST_PAT_LONG;
          res_pos_nxt    = '0;
          if (in_last) begin
            ml_nxt   = '0;
            tp_nxt   = '0;
            done_nxt = 1'b0;
          end
        end else if (txt_sat) begin
          tp_nxt         = TP_SAT;
          res_status_nxt = ST_TEXT_LONG;
          res_pos_nxt    = '0;
          if (in_last) begin
            ml_nxt   = '0;
            tp_nxt   = '0;
            done_nxt = 1'b0;
          end
        end else begin
          tp_nxt = tp_r + TW'(1);
          if (plen_r == '0) begin
            res_status_nxt = ST_MATCH;
            res_pos_nxt    = '0;
            if (in_last) begin
              ml_nxt   = '0;
              tp_nxt   = '0;
              done_nxt = 1'b0;
            end else begin
              done_nxt = 1'b1;
            end
          end else begin
            j_nxt = {1'b0, ml_r};
          end
        end
      end
    end else if (cmd.step) begin
      if (cont) begin
        j_nxt = j_fail;
      end else if (!mode_r) begin
        plen_nxt = plen_r + FW'(1);
        pidx_nxt = j_inc;
      end else if (hit) begin
        ml_nxt         = '0;
        res_status_nxt = ST_MATCH;
        res_pos_nxt    = start[PB-1:0];
        if (last_r) begin
          tp_nxt   = '0;
          done_nxt = 1'b0;
        end else begin
          done_nxt = 1'b1;
        end
      end else begin
        ml_nxt = j_inc[FW-1:0];
        if (last_r) begin
          res_status_nxt = ST_NONE;
          res_pos_nxt    = '0;
          ml_nxt         = '0;
          tp_nxt         = '0;
          done_nxt       = 1'b0;
        end
      end
    end

    if (cmd.emit) begin
      out_status_nxt = res_status_r;
      out_pos_nxt    = res_pos_r;
    end
  end

  assign pat_we     = cmd.take && !in_mode && !pat_full;
  assign pat_waddr  = txt_r ? '0 : plen_r[AW-1:0];
  assign fail_we    = cmd.step && !cont && !mode_r;
  assign fail_waddr = plen_r + FW'(1);

  // Memories: one write port each, read registered at the next walk index
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= in_data_byte;
    end
    if (fail_we) begin
      fail_mem[fail_waddr] <= j_inc[FW-1:0];
    end
    pat_rd_r  <= pat_mem[j_nxt[AW-1:0]];
    fail_rd_r <= fail_mem[j_nxt[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      pidx_r <= '1;
      ovf_r  <= 1'b0;
      ml_r   <= '0;
      tp_r   <= '0;
      done_r <= 1'b0;
      txt_r  <= 1'b0;
      j_r    <= '0;
      mode_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      plen_r <= plen_nxt;
      pidx_r <= pidx_nxt;
      ovf_r  <= ovf_nxt;
      ml_r   <= ml_nxt;
      tp_r   <= tp_nxt;
      done_r <= done_nxt;
      txt_r  <= txt_nxt;
      j_r    <= j_nxt;
      mode_r <= mode_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_status   = out_status_r;
  assign out_position = out_pos_r;

endmodule

/* rtl/kmp_substring_search.sv */
// Top level of the KMP substring search: configuration register, controller and datapath.
//
//   channel   direction  handshake                    payload
//   cfg       in/out     psel penable pwrite pready   paddr pwdata prdata
//   in        in         in_valid / in_ready          in_mode in_data_byte in_last
//   out       out        out_valid / out_ready        out_status out_position
//
// A word is accepted, then the failure-link walk runs compare by compare, each compare
// reading the pattern and failure memories at one index; a word that needs no compare
// skips the walk, and a result, where there is one, is then loaded into the output register.
// Reset (synchronous, active low) clears control state and the configuration register;
// the memories are not cleared, and failure entry zero is a constant minus one.
// A waiting result stalls the block only if a new result is ready before it is taken.
module kmp_substring_search import kmp_pkg::*; #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [POSITION_BITS-1:0] out_position
);

  logic      case_insensitive_r, case_insensitive_nxt;
  logic      cfg_wr;
  kmp_cmd_t  ctrl_cmd;
  kmp_stat_t dp_stat;

  // Configuration: write on the access phase, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case_insensitive_nxt = case_insensitive_r;
    prdata               = '0;
    unique case (paddr)
      REG_CASE: begin
        prdata = {31'd0, case_insensitive_r};
        if (cfg_wr) begin
          case_insensitive_nxt = pwdata[0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_insensitive_r <= 1'b0;
    end else begin
      case_insensitive_r <= case_insensitive_nxt;
    end
  end

  // Sequence words through accept, walk and result load
  kmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  // Hold the pattern, the failure table and the search state
  kmp_datapath #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .case_insensitive (case_insensitive_r),
    .in_mode          (in_mode),
    .in_data_byte     (in_data_byte),
    .in_last          (in_last),
    .cmd              (ctrl_cmd),
    .stat             (dp_stat),
    .out_status       (out_status),
    .out_position     (out_position)
  );

  // A word with no match carries position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_MATCH)) |-> (out_position == '0))
    else $error("position nonzero on a word without a match");

  // Reset drops any pending output word
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word survives reset");

  // No word is taken while a walk is in progress
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.step |-> !in_ready)
    else $error("input ready during a failure-link walk");

  // A result is loaded only when the output register is free or draining
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting output word");

endmodule
